// ===== src/pbfp_pkg.sv =====
// pbfp_pkg: types and constants shared by the protobuf field parser.
// Holds the transfer structs, the decoder state struct and the phase enum.
// No dependencies.
package pbfp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_VARINT  = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_EMPTY   = 3'd2;
    localparam logic [2:0] KIND_FIXED32 = 3'd3;
    localparam logic [2:0] KIND_FIXED64 = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_LENGTH   = 2'd1;
    localparam logic [1:0] ERR_VARINT   = 2'd2;
    localparam logic [1:0] ERR_WIRE     = 2'd3;

    // Wire types
    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LEN     = 3'd2;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    // Byte index of the tenth varint byte; continuing past it is an error
    localparam logic [3:0]  VARINT_LAST_IDX = 4'd9;
    localparam logic [31:0] FIXED32_BYTES   = 32'd4;
    localparam logic [31:0] FIXED64_BYTES   = 32'd8;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SKIP    = 3'd4,
        PH_DRAIN   = 3'd5
    } pbfp_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } pbfp_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] field_number;
        logic [63:0] value;
        logic [7:0]  payload_byte;
        logic        field_end;
        logic [1:0]  error_code;
        logic        message_end;
    } pbfp_result_t;

    typedef struct packed {
        pbfp_phase_t phase;
        logic [63:0] accumulator;
        logic [3:0]  byte_idx;        // varint byte index, shift is 7 * byte_idx
        logic [31:0] current_field;
        logic [2:0]  current_wire;
        logic [31:0] bytes_remaining;
        logic [31:0] declared_length;
    } pbfp_state_t;

endpackage

// ===== src/pbfp_decoder.sv =====
// pbfp_decoder: combinational next-state and result logic for one message byte.
// Depends on pbfp_pkg for the state, item and result types.
module pbfp_decoder
    import pbfp_pkg::*;
(
    input  pbfp_state_t  state,
    input  pbfp_item_t   item,
    output pbfp_state_t  state_next,
    output logic         res_valid,
    output pbfp_result_t res
);

    logic [6:0]  shift;
    logic [63:0] acc_new;
    logic        cont;
    logic        too_long;
    logic        fail_en;
    logic [1:0]  fail_code;
    logic        done_en;
    logic [2:0]  done_kind;
    logic [63:0] done_val;
    logic [7:0]  done_pb;
    logic [31:0] rem_dec;

    // Varint byte merge: 7 payload bits at 7 * byte_idx
    always_comb
    begin
        shift    = ({3'b000, state.byte_idx} << 3) - {3'b000, state.byte_idx};
        acc_new  = state.accumulator | ({57'd0, item.data_byte[6:0]} << shift[5:0]);
        cont     = item.data_byte[7];
        too_long = cont && (state.byte_idx == VARINT_LAST_IDX);
        rem_dec  = (state.bytes_remaining != 32'd0) ? state.bytes_remaining - 32'd1
                                                    : state.bytes_remaining;
    end

    // Phase decode
    always_comb
    begin
        state_next = state;
        res_valid  = 1'b0;
        res        = '0;
        fail_en    = 1'b0;
        fail_code  = ERR_NONE;
        done_en    = 1'b0;
        done_kind  = KIND_VARINT;
        done_val   = 64'd0;
        done_pb    = 8'd0;

        case (state.phase)
            PH_TAG, PH_VARINT, PH_LEN:
            begin
                state_next.accumulator = acc_new;
                state_next.byte_idx    = state.byte_idx + 4'd1;
                if (too_long)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_VARINT;
                end
                else if (cont)
                begin
                    if (item.last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_LENGTH;
                    end
                end
                else if (state.phase == PH_TAG)
                begin
                    state_next.current_field = acc_new[34:3];
                    state_next.current_wire  = acc_new[2:0];
                    state_next.accumulator   = 64'd0;
                    state_next.byte_idx      = 4'd0;
                    case (acc_new[2:0])
                        WIRE_VARINT:  state_next.phase = PH_VARINT;
                        WIRE_LEN:     state_next.phase = PH_LEN;
                        WIRE_FIXED32:
                        begin
                            state_next.phase           = PH_SKIP;
                            state_next.bytes_remaining = FIXED32_BYTES;
                        end
                        WIRE_FIXED64:
                        begin
                            state_next.phase           = PH_SKIP;
                            state_next.bytes_remaining = FIXED64_BYTES;
                        end
                        default:
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_WIRE;
                        end
                    endcase
                    if (!fail_en && item.last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_LENGTH;
                    end
                end
                else if (state.phase == PH_VARINT)
                begin
                    done_en   = 1'b1;
                    done_kind = KIND_VARINT;
                    done_val  = acc_new;
                end
                else
                begin
                    // Length prefix complete
                    if (acc_new[63:32] != 32'd0)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_LENGTH;
                    end
                    else if (acc_new[31:0] == 32'd0)
                    begin
                        state_next.declared_length = 32'd0;
                        done_en   = 1'b1;
                        done_kind = KIND_EMPTY;
                    end
                    else if (item.last)
                    begin
                        state_next.declared_length = acc_new[31:0];
                        fail_en   = 1'b1;
                        fail_code = ERR_LENGTH;
                    end
                    else
                    begin
                        state_next.declared_length = acc_new[31:0];
                        state_next.bytes_remaining = acc_new[31:0];
                        state_next.accumulator     = 64'd0;
                        state_next.byte_idx        = 4'd0;
                        state_next.phase           = PH_PAYLOAD;
                    end
                end
            end

            PH_PAYLOAD:
            begin
                state_next.bytes_remaining = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    done_en   = 1'b1;
                    done_kind = KIND_PAYLOAD;
                    done_val  = {32'd0, state.declared_length};
                    done_pb   = item.data_byte;
                end
                else if (item.last)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_LENGTH;
                end
                else
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.field_number = state.current_field;
                    res.value        = {32'd0, state.declared_length};
                    res.payload_byte = item.data_byte;
                end
            end

            PH_SKIP:
            begin
                state_next.bytes_remaining = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    done_en   = 1'b1;
                    done_kind = (state.current_wire == WIRE_FIXED32) ? KIND_FIXED32
                                                                     : KIND_FIXED64;
                end
                else if (item.last)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_LENGTH;
                end
            end

            PH_DRAIN:
            begin
                if (item.last)
                begin
                    state_next.phase       = PH_TAG;
                    state_next.accumulator = 64'd0;
                    state_next.byte_idx    = 4'd0;
                end
            end

            default:
            begin
                state_next.phase = PH_TAG;
            end
        endcase

        // Field complete: report and go back to tag
        if (done_en)
        begin
            state_next.accumulator = 64'd0;
            state_next.byte_idx    = 4'd0;
            state_next.phase       = PH_TAG;
            res_valid        = 1'b1;
            res.kind         = done_kind;
            res.field_number = state_next.current_field;
            res.value        = done_val;
            res.payload_byte = done_pb;
            res.field_end    = 1'b1;
            res.message_end  = item.last;
        end

        // Fault: report, then drain to end of message
        if (fail_en)
        begin
            state_next.accumulator     = 64'd0;
            state_next.byte_idx        = 4'd0;
            state_next.bytes_remaining = 32'd0;
            state_next.phase           = item.last ? PH_TAG : PH_DRAIN;
            res_valid        = 1'b1;
            res              = '0;
            res.kind         = KIND_ERROR;
            res.error_code   = fail_code;
            res.message_end  = 1'b1;
        end
    end

endmodule

// ===== src/protobuf_field_parser.sv =====
// protobuf_field_parser: streaming protobuf wire-format field decoder, top level.
// Depends on pbfp_pkg and pbfp_decoder.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one message byte per transfer,
//   with item.last set on the final byte of the message.
//   result channel (result_valid/result_ready/result) carries at most one result
//   per input byte: varint fields, each payload byte of a length field, empty length
//   fields, skipped fixed32/fixed64 fields, or an error.
//   A result is registered and appears on result the cycle after its byte is taken.
//   Throughput: one byte per cycle while results are taken; the decoder updates in a
//   single pass from the byte and the state register into the result register.
//   item_ready stays high while the result register is empty or being taken, so a
//   new byte enters in the same cycle a waiting result leaves.
//   When the receiver stalls, the result register holds and item_ready drops.
//   After an error, bytes are dropped up to and including the next last byte; a
//   consumer discards payload already passed for that message.
//   Reset (rst_n low) empties the result register and returns to expecting a tag.
module protobuf_field_parser
    import pbfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  pbfp_item_t   item,
    output logic         result_valid,
    input  logic         result_ready,
    output pbfp_result_t result
);

    pbfp_state_t  state_reg;
    pbfp_state_t  state_next;
    logic         result_valid_reg;
    pbfp_result_t result_reg;
    logic         dec_valid;
    pbfp_result_t dec_res;
    logic         accept;

    pbfp_decoder u_decoder (
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .res_valid  (dec_valid),
        .res        (dec_res)
    );

    assign item_ready   = !result_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= PH_TAG;
            state_reg.accumulator     <= 64'd0;
            state_reg.byte_idx        <= 4'd0;
            state_reg.current_field   <= 32'd0;
            state_reg.current_wire    <= 3'd0;
            state_reg.bytes_remaining <= 32'd0;
            state_reg.declared_length <= 32'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= dec_valid;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= dec_res;
        end
    end

    // Errors always close the message and never close a field
    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_ERROR) |-> (result.message_end && !result.field_end))
        else $error("error result without message_end or with field_end");

    // A last byte always leaves the decoder expecting a tag
    a_last_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last) |=> (state_reg.phase == PH_TAG))
        else $error("decoder not back at tag after last byte");

    // Payload and skip phases always have bytes left to consume
    a_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_PAYLOAD || state_reg.phase == PH_SKIP)
            |-> (state_reg.bytes_remaining != 32'd0))
        else $error("payload or skip phase with no bytes remaining");

    // An accepted byte with a result always presents it next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec_valid) |=> result_valid)
        else $error("decoded result lost");

endmodule
